/* src/png_ru_pkg.sv */
// ----------------------------------------------------------------------------
// png_ru_pkg: shared types and constants of the PNG row unfilter
// Channel widths, configuration codes, filter codes, queue entry layout and the
// small arithmetic helper used by the front end.
// ----------------------------------------------------------------------------
package png_ru_pkg;

    localparam int PNG_MAX_WIDTH   = 4096;
    localparam int PNG_MAX_BPP     = 4;
    localparam int PNG_PAL_ENTRIES = 256;
    localparam int QUEUE_DEPTH     = 4;

    localparam int S_DATA_W   = 40;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 8;
    localparam int M_USER_W   = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEXED = 2'd2;

    // row filter codes
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    // beat of an RGB triple that closes the run
    localparam logic [1:0] BEAT_BLUE = 2'd2;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_FILTER,
        KIND_PAL
    } item_kind_t;

    typedef struct packed {
        logic [2:0]            bpp;
        logic [CFG_DATA_W-1:0] width;
        logic                  indexed;
    } cfg_t;

    typedef struct packed {
        logic        is_pal;
        logic        indexed;
        logic        done;
        logic [7:0]  val;
        logic [23:0] rgb;
    } q_entry_t;

    // remainder by three: base-4 digit sums fold down since 4 = 1 mod 3
    function automatic logic [1:0] mod3(input logic [19:0] v);
        logic [2:0] pair [5];
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        for (int i = 0; i < 5; i++) begin
            pair[i] = 3'(v[4*i +: 2]) + 3'(v[4*i+2 +: 2]);
        end
        s1 = 5'(pair[0]) + 5'(pair[1]) + 5'(pair[2]) + 5'(pair[3]) + 5'(pair[4]);
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    endfunction

endpackage

/* src/png_ru_ram.sv */
// ----------------------------------------------------------------------------
// png_ru_ram: generic single-clock RAM
// One write port and one read port; read data registered, held while rd_en low.
// ----------------------------------------------------------------------------
module png_ru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/png_ru_front.sv */
// ----------------------------------------------------------------------------
// png_ru_front: stream classification and filter reconstruction
// Tracks the row position, sorts beats into filter, data and palette items,
// reads the prior row and undoes the row filter one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
module png_ru_front #(
    parameter int MAX_WIDTH = png_ru_pkg::PNG_MAX_WIDTH,
    parameter int MAX_BPP   = png_ru_pkg::PNG_MAX_BPP
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  png_ru_pkg::cfg_t                  cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // stream_byte[7:0], palette_index[15:8], palette_red[23:16],
    // palette_green[31:24], palette_blue[39:32]
    input  logic [png_ru_pkg::S_DATA_W-1:0]   s_tdata,
    // op[0]
    input  logic [png_ru_pkg::S_USER_W-1:0]   s_tuser,
    output logic                              q_push_valid,
    input  logic                              q_push_ready,
    output png_ru_pkg::q_entry_t              q_push_data
);
    import png_ru_pkg::*;

    localparam int ROW_DEPTH = MAX_WIDTH * MAX_BPP;
    localparam int LW        = $clog2(ROW_DEPTH + 1);
    localparam int XW        = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int SW        = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int CMPW      = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

    // row position: zero means a filter byte comes next
    logic [LW-1:0] col_reg, col_next;
    logic          first_reg, first_next;

    logic          accept;
    logic          in_pal;
    logic [2:0]    bpp_eff;
    logic [CMPW-1:0] w_ext;
    logic [LW-1:0] width_eff;
    logic [LW-1:0] len;
    logic [LW-1:0] x;
    logic [19:0]   xz;
    logic          row_end;
    logic [SW-1:0] slot;
    item_kind_t    in_kind;

    // stage 0: accepted item, aligned with the prior row read data
    logic            s0_valid_reg, s0_valid_next;
    item_kind_t      s0_kind_reg;
    logic [7:0]      s0_raw_reg;
    logic [XW-1:0]   s0_x_reg;
    logic [SW-1:0]   s0_slot_reg;
    logic            s0_done_reg;
    logic            s0_first_reg;
    logic            s0_indexed_reg;
    logic [7:0]      s0_pal_idx_reg;
    logic [23:0]     s0_rgb_reg;
    logic            s0_adv;

    logic [7:0]      filt_reg, filt_next;
    logic [7:0]      left_reg   [MAX_BPP];
    logic [7:0]      left_next  [MAX_BPP];
    logic [7:0]      upleft_reg [MAX_BPP];
    logic [7:0]      upleft_next[MAX_BPP];

    logic [7:0]      pr_rdata;
    logic [7:0]      up;
    logic [7:0]      left;
    logic [7:0]      upleft;
    logic [7:0]      rec;
    logic            wr_row;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = da + db;
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end
        if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    assign s_tready = !s0_valid_reg || s0_adv;
    assign accept   = s_tvalid && s_tready;
    assign in_pal   = s_tuser[0];

    always_comb begin
        if (cfg.indexed || cfg.bpp == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (cfg.bpp > 3'(MAX_BPP)) begin
            bpp_eff = 3'(MAX_BPP);
        end else begin
            bpp_eff = cfg.bpp;
        end
    end

    always_comb begin
        w_ext = CMPW'(cfg.width);
        if (w_ext == '0) begin
            width_eff = LW'(1);
        end else if (w_ext > CMPW'(MAX_WIDTH)) begin
            width_eff = LW'(MAX_WIDTH);
        end else begin
            width_eff = LW'(w_ext);
        end
    end

    assign len     = LW'(width_eff * LW'(bpp_eff));
    assign x       = col_reg - LW'(1);
    assign xz      = 20'(x);
    assign row_end = (col_reg >= len);

    always_comb begin
        case (bpp_eff)
            3'd2:    slot = SW'(xz[0]);
            3'd3:    slot = SW'(mod3(xz));
            3'd4:    slot = SW'(xz[1:0]);
            default: slot = '0;
        endcase
    end

    always_comb begin
        if (in_pal) begin
            in_kind = KIND_PAL;
        end else if (col_reg == '0) begin
            in_kind = KIND_FILTER;
        end else begin
            in_kind = KIND_DATA;
        end
    end

    always_comb begin
        col_next   = col_reg;
        first_next = first_reg;
        if (accept) begin
            case (in_kind)
                KIND_FILTER: col_next = LW'(1);
                KIND_DATA: begin
                    if (row_end) begin
                        col_next   = '0;
                        first_next = 1'b0;
                    end else begin
                        col_next = col_reg + LW'(1);
                    end
                end
                default: col_next = col_reg;
            endcase
        end
    end

    // filter bytes also take a stage so the previous row's last byte still
    // sees its own histories
    assign s0_adv = s0_valid_reg && (s0_kind_reg == KIND_FILTER || q_push_ready);

    always_comb begin
        if (accept) begin
            s0_valid_next = 1'b1;
        end else if (s0_adv) begin
            s0_valid_next = 1'b0;
        end else begin
            s0_valid_next = s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            first_reg    <= 1'b1;
            s0_valid_reg <= 1'b0;
            filt_reg     <= '0;
            for (int i = 0; i < MAX_BPP; i++) begin
                left_reg[i]   <= '0;
                upleft_reg[i] <= '0;
            end
        end else begin
            col_reg      <= col_next;
            first_reg    <= first_next;
            s0_valid_reg <= s0_valid_next;
            filt_reg     <= filt_next;
            left_reg     <= left_next;
            upleft_reg   <= upleft_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s0_kind_reg    <= in_kind;
            s0_raw_reg     <= s_tdata[7:0];
            s0_x_reg       <= x[XW-1:0];
            s0_slot_reg    <= slot;
            s0_done_reg    <= row_end;
            s0_first_reg   <= first_reg;
            s0_indexed_reg <= cfg.indexed;
            s0_pal_idx_reg <= s_tdata[15:8];
            s0_rgb_reg     <= {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
        end
    end

    png_ru_ram #(
        .WIDTH(8),
        .DEPTH(ROW_DEPTH)
    ) u_prior_row (
        .aclk    (aclk),
        .wr_en   (wr_row),
        .wr_addr (s0_x_reg),
        .wr_data (rec),
        .rd_en   (accept),
        .rd_addr (x[XW-1:0]),
        .rd_data (pr_rdata)
    );

    assign up     = s0_first_reg ? 8'd0 : pr_rdata;
    assign left   = left_reg[s0_slot_reg];
    assign upleft = upleft_reg[s0_slot_reg];

    always_comb begin
        case (filt_reg)
            FILT_SUB:   rec = s0_raw_reg + left;
            FILT_UP:    rec = s0_raw_reg + up;
            FILT_AVG:   rec = s0_raw_reg + 8'((9'(left) + 9'(up)) >> 1);
            FILT_PAETH: rec = s0_raw_reg + paeth(left, up, upleft);
            default:    rec = s0_raw_reg;
        endcase
    end

    assign wr_row = s0_adv && s0_kind_reg == KIND_DATA;

    always_comb begin
        filt_next   = filt_reg;
        left_next   = left_reg;
        upleft_next = upleft_reg;
        if (s0_adv) begin
            case (s0_kind_reg)
                KIND_FILTER: begin
                    filt_next = s0_raw_reg;
                    for (int i = 0; i < MAX_BPP; i++) begin
                        left_next[i]   = '0;
                        upleft_next[i] = '0;
                    end
                end
                KIND_DATA: begin
                    left_next[s0_slot_reg]   = rec;
                    upleft_next[s0_slot_reg] = up;
                end
                default: filt_next = filt_reg;
            endcase
        end
    end

    assign q_push_valid        = s0_valid_reg && s0_kind_reg != KIND_FILTER;
    assign q_push_data.is_pal  = (s0_kind_reg == KIND_PAL);
    assign q_push_data.indexed = s0_indexed_reg;
    assign q_push_data.done    = s0_done_reg;
    assign q_push_data.val     = (s0_kind_reg == KIND_PAL) ? s0_pal_idx_reg : rec;
    assign q_push_data.rgb     = s0_rgb_reg;

`ifndef SYNTHESIS
    a_row_end_clears_col: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_kind == KIND_DATA && row_end |=> col_reg == '0)
        else $error("row position not cleared at end of row");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s0_valid_reg && !s0_adv |=> s0_valid_reg && $stable(s0_x_reg)
            && $stable(s0_raw_reg))
        else $error("stalled stage 0 item changed");
`endif

endmodule

/* src/png_ru_queue.sv */
// ----------------------------------------------------------------------------
// png_ru_queue: short FIFO between reconstruction and output
// Lets the front keep taking bytes while the output side waits.
// ----------------------------------------------------------------------------
module png_ru_queue #(
    parameter int DEPTH = png_ru_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  png_ru_pkg::q_entry_t push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output png_ru_pkg::q_entry_t pop_data
);
    import png_ru_pkg::*;

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    q_entry_t        slot_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(DEPTH))
        else $error("queue count past depth");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + CNTW'(1))
        else $error("queue count out of step");
`endif

endmodule

/* src/png_ru_back.sv */
// ----------------------------------------------------------------------------
// png_ru_back: palette store and output beats
// Applies palette writes in stream order, looks up indexed bytes and sends one
// beat per byte, or an RGB triple in indexed mode.
// ----------------------------------------------------------------------------
module png_ru_back #(
    parameter int PALETTE_ENTRIES = png_ru_pkg::PNG_PAL_ENTRIES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_pop_valid,
    output logic                            q_pop_ready,
    input  png_ru_pkg::q_entry_t            q_pop_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_byte[7:0]
    output logic [png_ru_pkg::M_DATA_W-1:0] m_tdata,
    // last_of_run
    output logic                            m_tlast,
    // row_done[0]
    output logic [png_ru_pkg::M_USER_W-1:0] m_tuser
);
    import png_ru_pkg::*;

    localparam int PW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic        b_valid_reg, b_valid_next;
    logic        b_indexed_reg;
    logic        b_use_pal_reg;
    logic        b_done_reg;
    logic [7:0]  b_val_reg;
    logic [1:0]  beat_reg, beat_next;
    logic        present_reg, present_next;

    logic        b_load;
    logic        pop;
    logic        pop_data_item;
    logic        idx_in_range;
    logic        pal_wr;
    logic [23:0] pal_rdata;
    logic        out_beat;

    assign out_beat      = m_tvalid && m_tready;
    assign b_load        = !b_valid_reg || (out_beat && m_tlast);
    assign q_pop_ready   = b_load;
    assign pop           = q_pop_valid && b_load;
    assign pop_data_item = pop && !q_pop_data.is_pal;
    assign idx_in_range  = (9'(q_pop_data.val) < 9'(PALETTE_ENTRIES));
    assign pal_wr        = pop && q_pop_data.is_pal && idx_in_range;

    png_ru_ram #(
        .WIDTH(24),
        .DEPTH(PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr),
        .wr_addr (q_pop_data.val[PW-1:0]),
        .wr_data (q_pop_data.rgb),
        .rd_en   (pop_data_item),
        .rd_addr (q_pop_data.val[PW-1:0]),
        .rd_data (pal_rdata)
    );

    always_comb begin
        b_valid_next = b_valid_reg;
        beat_next    = beat_reg;
        present_next = present_reg || pal_wr;
        if (b_load) begin
            b_valid_next = pop_data_item;
            beat_next    = '0;
        end else if (out_beat) begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            beat_reg    <= '0;
            present_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
            beat_reg    <= beat_next;
            present_reg <= present_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_data_item) begin
            b_indexed_reg <= q_pop_data.indexed;
            b_use_pal_reg <= q_pop_data.indexed && present_reg && idx_in_range;
            b_done_reg    <= q_pop_data.done;
            b_val_reg     <= q_pop_data.val;
        end
    end

    always_comb begin
        if (!b_use_pal_reg) begin
            m_tdata = b_val_reg;
        end else begin
            case (beat_reg)
                2'd0:    m_tdata = pal_rdata[23:16];
                2'd1:    m_tdata = pal_rdata[15:8];
                default: m_tdata = pal_rdata[7:0];
            endcase
        end
    end

    assign m_tvalid   = b_valid_reg;
    assign m_tlast    = !b_indexed_reg || beat_reg == BEAT_BLUE;
    assign m_tuser[0] = m_tlast && b_done_reg;

`ifndef SYNTHESIS
    a_triple_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        out_beat && !m_tlast |=> m_tvalid && $stable(b_val_reg))
        else $error("RGB triple broken off");
`endif

endmodule

/* src/png_row_unfilter.sv */
// Throughput: one stream byte per cycle while the queue has room; in indexed mode
// three output beats per byte, so the output port sets the rate, and the back end
// takes no new byte until the last beat of its triple is sent.
// The prior-row RAM read and write at one byte per cycle set the front rate.
// Reset: synchronous, active low; clears row position, queue, palette flag and
// registers. Prior row and palette RAMs are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// png_row_unfilter: PNG row filter reconstruction with palette expansion
// Configuration registers, front end, queue and output back end.
// ----------------------------------------------------------------------------
module png_row_unfilter #(
    parameter int MAX_WIDTH       = png_ru_pkg::PNG_MAX_WIDTH,
    parameter int MAX_BPP         = png_ru_pkg::PNG_MAX_BPP,
    parameter int PALETTE_ENTRIES = png_ru_pkg::PNG_PAL_ENTRIES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [png_ru_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [png_ru_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // stream_byte[7:0], palette_index[15:8], palette_red[23:16],
    // palette_green[31:24], palette_blue[39:32]
    input  logic [png_ru_pkg::S_DATA_W-1:0]   s_tdata,
    // op[0]
    input  logic [png_ru_pkg::S_USER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_byte[7:0]
    output logic [png_ru_pkg::M_DATA_W-1:0]   m_tdata,
    // last_of_run
    output logic                              m_tlast,
    // row_done[0]
    output logic [png_ru_pkg::M_USER_W-1:0]   m_tuser
);
    import png_ru_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    logic     q_push_valid;
    logic     q_push_ready;
    q_entry_t q_push_data;
    logic     q_pop_valid;
    logic     q_pop_ready;
    q_entry_t q_pop_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BPP:     cfg_next.bpp     = cfg_data[2:0];
                CFG_WIDTH:   cfg_next.width   = cfg_data;
                CFG_INDEXED: cfg_next.indexed = cfg_data[0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bpp     <= 3'd1;
            cfg_reg.width   <= CFG_DATA_W'(1);
            cfg_reg.indexed <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    png_ru_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BPP   (MAX_BPP)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .q_push_valid (q_push_valid),
        .q_push_ready (q_push_ready),
        .q_push_data  (q_push_data)
    );

    png_ru_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    png_ru_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_pop_valid (q_pop_valid),
        .q_pop_ready (q_pop_ready),
        .q_pop_data  (q_pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

`ifndef SYNTHESIS
    a_cfg_write_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index == CFG_WIDTH |=> cfg_reg.width == $past(cfg_data))
        else $error("width register write lost");

    a_cfg_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_valid |=> $stable(cfg_reg))
        else $error("configuration changed without a write");
`endif

endmodule

/* tb/tb_png_row_unfilter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_row_unfilter: self-checking bench for the PNG row unfilter
// Streams filter bytes, row bytes and palette writes through the slave port
// in random bursts, predicts every output beat from a local copy of the
// unfilter state, and checks each master beat against the oldest prediction.
// The receiver stalls on its own pattern and holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_png_row_unfilter;
    import png_ru_pkg::*;

    localparam int ROW_BYTES = PNG_MAX_WIDTH * PNG_MAX_BPP;
    localparam int PAL_USED  = 8;

    localparam logic OP_STREAM  = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [7:0] FILT_NONE = 8'd0;

    typedef struct packed {
        logic                op;
        logic [S_DATA_W-1:0] data;
    } stream_item_t;

    typedef struct {
        logic [7:0] pixel;
        logic       last;
        logic       row_end;
    } out_beat_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [S_USER_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic [M_USER_W-1:0]   m_tuser;

    png_row_unfilter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #500000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // unfilter state as the block should hold it
    // ------------------------------------------------------------------
    logic [2:0]            reg_bpp;
    logic [CFG_DATA_W-1:0] reg_width;
    logic                  reg_indexed;

    logic [7:0]   prior_row [ROW_BYTES];
    int unsigned  row_pos;
    logic [7:0]   row_kind;
    logic         on_first_row;
    logic [7:0]   left_hist [4];
    logic [7:0]   upleft_hist [4];
    logic [23:0]  pal_rgb [PNG_PAL_ENTRIES];
    logic         pal_written;

    stream_item_t feed_q [$];
    out_beat_t    pixel_expect [$];
    int           mismatch_count = 0;

    function automatic int unsigned eff_stride(input logic [2:0] bpp, input logic idx);
        if (idx || bpp == 3'd0) return 1;
        if (bpp > PNG_MAX_BPP) return PNG_MAX_BPP;
        return bpp;
    endfunction

    function automatic int unsigned row_len(input logic [2:0] bpp,
                                            input logic [CFG_DATA_W-1:0] width,
                                            input logic idx);
        int unsigned w;
        w = (width == 0) ? 1 : ((width > PNG_MAX_WIDTH) ? PNG_MAX_WIDTH : width);
        return w * eff_stride(bpp, idx);
    endfunction

    function automatic logic [7:0] paeth_guess(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
        int p, da, db, dc;
        p  = int'(a) + int'(b) - int'(c);
        da = p - int'(a);
        db = p - int'(b);
        dc = p - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    function automatic void clear_model();
        reg_bpp      = 3'd1;
        reg_width    = 13'd1;
        reg_indexed  = 1'b0;
        row_pos      = 0;
        row_kind     = 8'd0;
        on_first_row = 1'b1;
        pal_written  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            left_hist[i]   = 8'd0;
            upleft_hist[i] = 8'd0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_BPP:     reg_bpp = val[2:0];
            CFG_WIDTH:   reg_width = val;
            CFG_INDEXED: reg_indexed = val[0];
            default: ;
        endcase
    endfunction

    function automatic void unfilter_byte(input logic [7:0] raw);
        int unsigned stride, len, x, slot;
        logic [7:0]  up, left, upleft, rec;
        logic [8:0]  sum;
        logic [23:0] rgb;
        logic        row_end;
        if (row_pos == 0) begin
            // filter type byte: latch kind, restart histories
            row_kind = raw;
            for (int i = 0; i < 4; i++) begin
                left_hist[i]   = 8'd0;
                upleft_hist[i] = 8'd0;
            end
            row_pos = 1;
            return;
        end
        stride = eff_stride(reg_bpp, reg_indexed);
        len    = row_len(reg_bpp, reg_width, reg_indexed);
        x      = row_pos - 1;
        if (x >= ROW_BYTES) x = ROW_BYTES - 1;
        slot   = x % stride;
        up     = on_first_row ? 8'd0 : prior_row[x];
        left   = left_hist[slot];
        upleft = upleft_hist[slot];
        sum    = {1'b0, left} + {1'b0, up};
        case (row_kind)
            FILT_SUB:   rec = raw + left;
            FILT_UP:    rec = raw + up;
            FILT_AVG:   rec = raw + sum[8:1];
            FILT_PAETH: rec = raw + paeth_guess(left, up, upleft);
            default:    rec = raw;
        endcase
        left_hist[slot]   = rec;
        upleft_hist[slot] = up;
        prior_row[x]      = rec;
        row_end = (x + 1 >= len);
        if (row_end) begin
            row_pos      = 0;
            on_first_row = 1'b0;
        end else begin
            row_pos = x + 2;
        end
        if (reg_indexed) begin
            rgb = pal_written ? pal_rgb[rec] : {3{rec}};
            pixel_expect.push_back('{rgb[23:16], 1'b0, 1'b0});
            pixel_expect.push_back('{rgb[15:8], 1'b0, 1'b0});
            pixel_expect.push_back('{rgb[7:0], 1'b1, row_end});
        end else begin
            pixel_expect.push_back('{rec, 1'b1, row_end});
        end
    endfunction

    // ------------------------------------------------------------------
    // slave-side driver: bursts with random gaps, prediction on accept
    // ------------------------------------------------------------------
    int unsigned  burst_left = 0;
    int unsigned  gap_left   = 0;
    stream_item_t next_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_model();
        end else begin
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_PALETTE) begin
                    pal_rgb[s_tdata[15:8]] = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
                    pal_written = 1'b1;
                end else begin
                    unfilter_byte(s_tdata[7:0]);
                end
            end
            // hold the beat while it is offered and not taken
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (feed_q.size() != 0) begin
                    next_item = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.data;
                    s_tuser  <= next_item.op;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // master-side receiver: stall pattern plus requested long hold-offs
    // ------------------------------------------------------------------
    int unsigned hold_serial = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    int unsigned pat_left    = 0;
    logic [15:0] stall_pat   = '1;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_serial != hold_seen) begin
                hold_seen = hold_serial;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_left = 16;
                    case ($urandom_range(0, 3))
                        0: stall_pat = '1;
                        1: stall_pat = 16'($urandom);
                        2: stall_pat = 16'($urandom & $urandom);
                        default: stall_pat = 16'($urandom | $urandom);
                    endcase
                end
                m_tready  <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
                pat_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // output check against the oldest predicted beat
    // ------------------------------------------------------------------
    out_beat_t seen_exp;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_expect.size() == 0) begin
                $error("unexpected output beat: pixel_byte %0h", m_tdata);
                mismatch_count++;
            end else begin
                seen_exp = pixel_expect.pop_front();
                if (m_tdata !== seen_exp.pixel) begin
                    $error("pixel_byte: expected %0h, got %0h", seen_exp.pixel, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== seen_exp.last) begin
                    $error("last_of_run: expected %0b, got %0b", seen_exp.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser[0] !== seen_exp.row_end) begin
                    $error("row_done: expected %0b, got %0b", seen_exp.row_end, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int unsigned gen_extent = 0;  // prior-row bytes written so far
    logic        pal_filled = 1'b0;

    task automatic wait_idle();
        do @(negedge aclk);
        while (feed_q.size() != 0 || s_tvalid || pixel_expect.size() != 0);
        // filter bytes and palette writes may still be in the pipe
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [2:0] bpp, input logic [CFG_DATA_W-1:0] width,
                              input logic idx);
        wait_idle();
        write_reg(CFG_BPP, {10'($urandom), bpp});
        write_reg(CFG_WIDTH, width);
        write_reg(CFG_INDEXED, {12'($urandom), idx});
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] raw);
        feed_q.push_back('{OP_STREAM, {32'($urandom), raw}});
    endfunction

    function automatic void push_palette(input logic [7:0] idx, input logic [23:0] rgb);
        feed_q.push_back('{OP_PALETTE, {rgb[7:0], rgb[15:8], rgb[23:16], idx, 8'($urandom)}});
    endfunction

    // one whole row, with palette writes sprinkled in once the palette is set up
    function automatic void queue_row(input logic [7:0] kind, input int unsigned nbytes);
        push_byte(kind);
        for (int i = 0; i < nbytes; i++) begin
            if (pal_filled && $urandom_range(0, 9) == 0)
                push_palette(8'($urandom), 24'($urandom));
            push_byte(pick_byte());
        end
        if (nbytes > gen_extent) gen_extent = nbytes;
    endfunction

    // indexed row whose bytes look up only the palette entries written up front
    function automatic void queue_index_row(input int unsigned nbytes);
        push_byte(FILT_NONE);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0)
                push_palette(8'($urandom), 24'($urandom));
            push_byte(8'($urandom_range(0, PAL_USED - 1)));
        end
        if (nbytes > gen_extent) gen_extent = nbytes;
    endfunction

    function automatic logic [7:0] pick_kind();
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r < 10) return 8'(r % 5);
        return 8'($urandom_range(5, 255));
    endfunction

    int unsigned   random_items;
    int unsigned   phase_no;
    int unsigned   maxw, nwidth, nbytes;
    logic [2:0]    r_bpp;
    logic          r_idx;

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // opening rows set up the prior row; the first sees zeros above
        set_config(3'd4, 13'd2, 1'b0);
        queue_row(FILT_PAETH, 8);
        queue_row(FILT_PAETH, 8);

        // every filter kind plus unknown kinds on a short row
        set_config(3'd2, 13'd2, 1'b0);
        queue_row(FILT_NONE, 4);
        queue_row(FILT_SUB, 4);
        queue_row(FILT_UP, 4);
        queue_row(FILT_AVG, 4);
        queue_row(FILT_PAETH, 4);
        queue_row(8'd5, 4);
        queue_row(8'hFF, 4);

        // out-of-range stride and width
        set_config(3'd0, 13'd0, 1'b0);
        queue_row(FILT_SUB, 1);
        set_config(3'd7, 13'd2, 1'b0);
        queue_row(FILT_AVG, 8);

        // widths at and past the maximum, changed mid-row; the short
        // width then ends the row on the next byte
        set_config(3'd1, 13'(PNG_MAX_WIDTH), 1'b0);
        push_byte(FILT_UP);
        repeat (3) push_byte(pick_byte());
        wait_idle();
        write_reg(CFG_WIDTH, 13'h1FFF);
        repeat (2) push_byte(pick_byte());
        wait_idle();
        write_reg(CFG_WIDTH, 13'd1);
        push_byte(pick_byte());

        // indexed mode without a palette repeats the byte; stride ignores bpp
        set_config(3'd3, 13'd4, 1'b1);
        queue_row(FILT_AVG, 4);

        // write a few palette entries; lookups through it stay among them
        for (int i = 0; i < PAL_USED; i++) push_palette(8'(i), 24'($urandom));
        pal_filled = 1'b1;
        queue_index_row(4);
        queue_index_row(4);

        // long receiver hold-off while the sender keeps offering
        set_config(3'd2, 13'd4, 1'b0);
        hold_serial++;
        queue_row(FILT_UP, 8);
        queue_row(FILT_NONE, 8);

        random_items = 0;
        phase_no     = 0;
        while (random_items < 16) begin
            r_idx  = ($urandom_range(0, 2) == 0);
            r_bpp  = 3'($urandom_range(0, 7));
            maxw   = gen_extent / eff_stride(r_bpp, r_idx);
            nwidth = ($urandom_range(0, 7) == 0) ? maxw
                                                 : $urandom_range(0, (maxw < 6) ? maxw : 6);
            set_config(r_bpp, 13'(nwidth), r_idx);
            if (phase_no == 3) hold_serial++;
            nbytes = row_len(r_bpp, 13'(nwidth), r_idx);
            repeat ($urandom_range(1, 3)) begin
                if (r_idx) queue_index_row(nbytes);
                else queue_row(pick_kind(), nbytes);
                random_items += nbytes + 1;
            end
            phase_no++;
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
